[sv/dpf_pkg.sv]
// shared types, constants and command codes of the dithered pwm fader
package dpf_pkg;

  localparam int unsigned NumChannelsDef = 8;
  localparam int unsigned CurveSizeDef   = 256;

  localparam int unsigned DutyW  = 10;
  localparam int unsigned CountW = 9;
  localparam int unsigned AccW   = 11;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned CurveW = 9;

  localparam logic [DutyW-1:0] DutyFull     = 10'd1000;
  localparam logic [DutyW-1:0] MinDutyReset = 10'd50;
  localparam logic [12:0]      FadeMaxMs    = 13'd5000;
  localparam logic [12:0]      FadeHalfStep = 13'd5;
  // 2^16 / 10 rounded up, exact for sums up to 5005
  localparam logic [13:0]      StepRecip    = 14'd6554;

  // iterative divider widths
  localparam int unsigned DivW = 20;
  localparam int unsigned DvsW = 11;

  typedef enum logic [2:0] {
    CMD_PWM_TICK   = 3'd0,
    CMD_FADE_TICK  = 3'd1,
    CMD_ADD        = 3'd2,
    CMD_SET_DUTY   = 3'd3,
    CMD_SET_FADE   = 3'd4,
    CMD_LOAD_CURVE = 3'd5,
    CMD_RSVD6      = 3'd6,
    CMD_RSVD7      = 3'd7
  } cmd_e;

  localparam logic REG_MIN_DUTY = 1'b0;
  localparam logic REG_INVERT   = 1'b1;

  typedef struct packed {
    logic [AccW-1:0]   acc;
    logic [CountW-1:0] total;
    logic [CountW-1:0] count;
    logic              busy;
    logic [DutyW-1:0]  start;
    logic [DutyW-1:0]  target;
    logic [DutyW-1:0]  now;
  } chan_t;

endpackage

[sv/dpf_ram.sv]
// single port write, single port read ram with registered read data
module dpf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/dpf_div.sv]
// restoring divider, one quotient bit per cycle
module dpf_div
  import dpf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DvsW:0]   trial;
  logic            ge;

  always_comb begin
    trial  = {rem_q, quo_q[DivW-1]};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DvsW'(trial - {1'b0, dvs_q}) : DvsW'(trial);
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[sv/dithered_pwm_fader.sv]
// top level of the dithered pwm fader with curve fades
// channel commands pass through the read and execute states to the result register, a pwm
// tick reads and updates each channel in turn, and a fade tick does the same with one pass of
// the shared divider, then a reciprocal multiply by the curve size, for each fading channel
// throughput: one request at a time; the next is taken once the result is registered
// reset clears channel active bits, pin levels, the invert bit and control, and sets min duty
// to MinDutyReset; the channel and curve rams are not cleared, inactive channels read as zero
module dithered_pwm_fader
  import dpf_pkg::*;
#(
  parameter int unsigned NumChannels = NumChannelsDef,
  parameter int unsigned CurveSize   = CurveSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command, channel, duty, fade time, curve index, curve word
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pin levels, present duty, accepted, fading
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  localparam int unsigned AW  = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int unsigned CIW = $clog2(CurveSize);
  localparam int unsigned MagW = 19;
  localparam int unsigned RcpS = MagW + CIW;
  localparam int unsigned RcpW = MagW + 1;
  localparam logic [RcpW-1:0] CurveRcp =
    RcpW'(((64'd1 << RcpS) + 64'(CurveSize) - 64'd1) / 64'(CurveSize));

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_WRD, ST_WEXE, ST_DIV1, ST_CRD,
    ST_MUL, ST_D2S, ST_WB, ST_DONE
  } state_e;

  state_e state_q, state_d;

  logic [DutyW-1:0]       min_duty_q;
  logic                   invert_q;
  logic [NumChannels-1:0] act_q, act_d;
  logic [NumChannels-1:0] pin_q, pin_d, lvl_q, lvl_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic                   res_acc_q, res_acc_d, res_fad_q, res_fad_d;
  logic [DutyW-1:0]       res_duty_q, res_duty_d;
  logic                   m_valid_q, m_valid_d;
  logic [23:0]            out_q, out_d;

  cmd_e             cmd_q;
  logic [2:0]       ch_q;
  logic [DutyW-1:0] d_q;
  logic [TimeW-1:0] t_q;
  logic [7:0]       ci_q;
  logic [CurveW-1:0] cv_q;
  logic signed [20:0] prod_q, prod_d;
  logic [DivW-1:0]  quo2_q;

  // channel ram
  logic          cw_we;
  logic [AW-1:0] cw_addr, c_raddr;
  chan_t         cw_data, rec;
  logic [$bits(chan_t)-1:0] c_rdata;

  dpf_ram #(.Width($bits(chan_t)), .Depth(NumChannels)) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (cw_we),
    .waddr_i (cw_addr),
    .wdata_i (cw_data),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );
  assign rec = chan_t'(c_rdata);

  // curve ram
  logic              kw_we;
  logic [CIW-1:0]    kw_addr, k_raddr;
  logic [CurveW-1:0] k_rdata;

  dpf_ram #(.Width(CurveW), .Depth(CurveSize)) u_curve_ram (
    .clk_i   (clk_i),
    .we_i    (kw_we),
    .waddr_i (kw_addr),
    .wdata_i (cv_q),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  // shared divider
  logic            div_start, div_busy, div_done;
  logic [DivW-1:0] div_dvd, div_quot;
  logic [DvsW-1:0] div_dvs;

  dpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // command side helpers
  logic          ch_valid, live;
  logic [AW-1:0] ch_idx;
  logic [DutyW-1:0] lo, d_dir;
  logic [12:0]   t_cl, t_rnd;
  logic [26:0]   step_prod;
  logic [CountW-1:0] steps;

  assign ch_valid = 32'(ch_q) < NumChannels;
  assign ch_idx   = AW'(ch_q);
  assign live     = ch_valid && act_q[ch_idx];
  assign lo       = (min_duty_q > DutyFull) ? DutyFull : min_duty_q;
  assign d_dir    = (d_q != '0 && d_q < lo) ? lo : d_q;
  assign t_cl     = (t_q > TimeW'(FadeMaxMs)) ? FadeMaxMs : 13'(t_q);
  assign t_rnd    = t_cl + FadeHalfStep;
  assign step_prod = 27'(t_rnd) * 27'(StepRecip);
  assign steps    = (step_prod[24:16] == '0) ? CountW'(1) : step_prod[24:16];

  // walk side helpers
  logic [AccW:0]      pwm_sum;
  logic               pwm_hi;
  logic [CountW-1:0]  cnt1, tot1;
  logic [DivW-1:0]    quo_cl;
  logic signed [10:0] range_s;
  logic [DivW-1:0]    prod_mag;
  logic [39:0]        rcp_prod;
  logic signed [21:0] v_s;
  logic [DutyW-1:0]   v_cl;
  logic               fade_end;
  logic               is_me;

  assign pwm_sum  = (AccW+1)'(rec.acc) + (AccW+1)'(rec.now);
  assign pwm_hi   = pwm_sum >= (AccW+1)'(DutyFull);
  assign cnt1     = rec.count + 1'b1;
  assign tot1     = (rec.total == '0) ? CountW'(1) : rec.total;
  assign quo_cl   = (div_quot >= DivW'(CurveSize)) ? DivW'(CurveSize - 1) : div_quot;
  assign range_s  = $signed({1'b0, rec.target}) - $signed({1'b0, rec.start});
  assign prod_d   = range_s * $signed({1'b0, k_rdata});
  assign prod_mag = prod_q[20] ? DivW'(-prod_q) : DivW'(prod_q);
  assign rcp_prod = 40'(prod_mag) * 40'(CurveRcp);
  assign v_s      = $signed({1'b0, rec.start}) +
                    (prod_q[20] ? -$signed({1'b0, quo2_q}) : $signed({1'b0, quo2_q}));
  assign v_cl     = (v_s < 0) ? '0 :
                    (v_s > $signed(22'(DutyFull))) ? DutyFull : DutyW'(v_s);
  assign fade_end = cnt1 >= tot1;
  assign is_me    = ch_q == 3'(idx_q);

  assign c_raddr = (state_q == ST_READ || state_q == ST_EXEC) ? ch_idx : idx_q;
  assign k_raddr = CIW'(quo_cl);
  assign kw_addr = CIW'(ci_q);
  assign div_dvd = DivW'(cnt1) * DivW'(CurveSize);
  assign div_dvs = DvsW'(tot1);

  always_comb begin
    chan_t nrec;
    logic  set_act;
    state_d    = state_q;
    act_d      = act_q;
    pin_d      = pin_q;
    lvl_d      = lvl_q;
    idx_d      = idx_q;
    res_acc_d  = res_acc_q;
    res_fad_d  = res_fad_q;
    res_duty_d = res_duty_q;
    m_valid_d  = m_valid_q;
    out_d      = out_q;
    cw_we      = 1'b0;
    cw_addr    = idx_q;
    cw_data    = rec;
    kw_we      = 1'b0;
    div_start  = 1'b0;
    nrec       = rec;
    set_act    = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          res_acc_d  = 1'b0;
          res_fad_d  = 1'b0;
          res_duty_d = '0;
          idx_d      = '0;
          lvl_d      = '0;
          if (cmd_e'(s_axis_tdata[2:0]) == CMD_PWM_TICK ||
              cmd_e'(s_axis_tdata[2:0]) == CMD_FADE_TICK) begin
            state_d = ST_WRD;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        cw_addr = ch_idx;
        unique case (cmd_q)
          CMD_ADD: begin
            if (ch_valid && !live) begin
              nrec      = '0;
              cw_we     = 1'b1;
              set_act   = 1'b1;
              res_acc_d = 1'b1;
            end
          end
          CMD_SET_DUTY: begin
            if (live) begin
              nrec.now    = d_dir;
              nrec.target = d_dir;
              nrec.busy   = 1'b0;
              cw_we       = 1'b1;
              res_acc_d   = 1'b1;
            end
          end
          CMD_SET_FADE: begin
            if (live) begin
              if (t_q == '0) begin
                nrec.now    = d_dir;
                nrec.target = d_dir;
                nrec.busy   = 1'b0;
              end else begin
                nrec.start  = rec.now;
                nrec.target = d_q;
                nrec.total  = steps;
                nrec.count  = '0;
                nrec.busy   = rec.now != d_q;
              end
              cw_we     = 1'b1;
              res_acc_d = 1'b1;
            end
          end
          CMD_LOAD_CURVE: begin
            if (32'(ci_q) < CurveSize) begin
              kw_we     = 1'b1;
              res_acc_d = 1'b1;
            end
          end
          default: ;
        endcase
        cw_data = nrec;
        if (set_act) begin
          act_d[ch_idx] = 1'b1;
        end
        if (live || set_act) begin
          res_duty_d = nrec.now;
          res_fad_d  = nrec.busy;
        end
        state_d = ST_DONE;
      end
      ST_WRD: state_d = ST_WEXE;
      ST_WEXE: begin
        res_acc_d = 1'b1;
        state_d   = ST_WRD;
        if (act_q[idx_q] && cmd_q == CMD_PWM_TICK) begin
          nrec.acc     = pwm_hi ? AccW'(pwm_sum - (AccW+1)'(DutyFull)) : AccW'(pwm_sum);
          cw_we        = 1'b1;
          lvl_d[idx_q] = pwm_hi ^ invert_q;
        end else if (act_q[idx_q] && rec.busy) begin
          div_start = 1'b1;
          state_d   = ST_DIV1;
        end
        cw_data = nrec;
        if (state_d == ST_WRD) begin
          if (is_me && act_q[idx_q]) begin
            res_duty_d = nrec.now;
            res_fad_d  = nrec.busy;
          end
          if (idx_q == AW'(NumChannels - 1)) begin
            if (cmd_q == CMD_PWM_TICK) begin
              pin_d = lvl_d;
            end
            state_d = ST_DONE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_DIV1: if (div_done) state_d = ST_CRD;
      ST_CRD:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_D2S;
      ST_D2S:  state_d = ST_WB;
      ST_WB: begin
        nrec.count = cnt1;
        nrec.now   = fade_end ? rec.target : v_cl;
        nrec.busy  = !fade_end;
        cw_data    = nrec;
        cw_we      = 1'b1;
        if (is_me) begin
          res_duty_d = nrec.now;
          res_fad_d  = nrec.busy;
        end
        if (idx_q == AW'(NumChannels - 1)) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_WRD;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          out_d     = {4'b0, res_fad_q, res_acc_q, res_duty_q, 8'(pin_q)};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      min_duty_q <= MinDutyReset;
      invert_q   <= 1'b0;
      act_q      <= '0;
      pin_q      <= '0;
      m_valid_q  <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      pin_q     <= pin_d;
      m_valid_q <= m_valid_d;
      idx_q     <= idx_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_MIN_DUTY: min_duty_q <= cfg_data_i;
          REG_INVERT:   invert_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q      <= lvl_d;
    res_acc_q  <= res_acc_d;
    res_fad_q  <= res_fad_d;
    res_duty_q <= res_duty_d;
    out_q      <= out_d;
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_D2S) begin
      quo2_q <= DivW'(rcp_prod >> RcpS);
    end
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      cmd_q <= cmd_e'(s_axis_tdata[2:0]);
      ch_q  <= s_axis_tdata[5:3];
      d_q   <= (s_axis_tdata[21:6] > TimeW'(DutyFull)) ? DutyFull : DutyW'(s_axis_tdata[21:6]);
      t_q   <= s_axis_tdata[37:22];
      ci_q  <= s_axis_tdata[45:38];
      cv_q  <= s_axis_tdata[54:46];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_pin_inactive_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pin_q & ~act_q) == '0) else $error("pin high on inactive channel");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw_we || kw_we) |-> state_q != ST_IDLE) else $error("ram write while idle");

endmodule
